// ===== rtl/core/dtyp_pkg.sv =====
// Shared constants and the arctangent table for the direction to yaw and pitch block.
package dtyp_pkg;

    localparam int DEF_COORD_WIDTH  = 16;
    localparam int DEF_ANGLE_WIDTH  = 16;
    localparam int DEF_CORDIC_STEPS = 16;

    localparam int GUARD      = 26;
    localparam int MARGIN     = 4;
    localparam int KGAIN_W    = 31;
    localparam int KGAIN_FRAC = 30;
    localparam int ATAN_LEN   = 24;
    localparam int ACC_W      = 32;
    localparam int ATAN_IDX_W = 5;

    localparam logic [KGAIN_W-1:0] KGAIN_Q30    = 31'd1768195363;
    localparam logic [ACC_W-1:0]   HALF_TURN    = 32'h8000_0000;
    localparam logic [ACC_W-1:0]   QUARTER_TURN = 32'h4000_0000;

    function automatic logic [ACC_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [ACC_W-1:0] a;
        unique case (idx)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10680862;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/dtyp_if.sv =====
// Valid/ready channel interfaces for direction vectors and for yaw and pitch angles.
interface dtyp_in_if #(
    parameter int COORD_WIDTH = dtyp_pkg::DEF_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] dx;
    logic signed [COORD_WIDTH-1:0] dy;
    logic signed [COORD_WIDTH-1:0] dz;

    modport source (output valid, output dx, output dy, output dz, input ready);
    modport sink   (input valid, input dx, input dy, input dz, output ready);
endinterface

interface dtyp_out_if #(
    parameter int ANGLE_WIDTH = dtyp_pkg::DEF_ANGLE_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [ANGLE_WIDTH-1:0] yaw;
    logic [ANGLE_WIDTH-1:0] pitch;

    modport source (output valid, output yaw, output pitch, input ready);
    modport sink   (input valid, input yaw, input pitch, output ready);
endinterface

// ===== rtl/core/dtyp_cordic_stage.sv =====
// One registered CORDIC vectoring iteration with valid/ready flow control and sideband.
module dtyp_cordic_stage #(
    parameter int W      = 46,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [W-1:0]            i_x,
    input  logic signed [W-1:0]            i_y,
    input  logic [dtyp_pkg::ACC_W-1:0]     i_z,
    input  logic [SIDE_W-1:0]              i_side,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [W-1:0]            o_x,
    output logic signed [W-1:0]            o_y,
    output logic [dtyp_pkg::ACC_W-1:0]     o_z,
    output logic [SIDE_W-1:0]              o_side
);

    localparam int IDX_W = dtyp_pkg::ATAN_IDX_W;
    localparam logic [IDX_W-1:0] ATAN_IDX = IDX_W'(SHIFT);

    logic signed [W-1:0]          xs;
    logic signed [W-1:0]          ys;
    logic signed [W-1:0]          n_x;
    logic signed [W-1:0]          n_y;
    logic [dtyp_pkg::ACC_W-1:0]   n_z;
    logic [dtyp_pkg::ACC_W-1:0]   step_angle;
    logic                         r_valid;
    logic signed [W-1:0]          r_x;
    logic signed [W-1:0]          r_y;
    logic [dtyp_pkg::ACC_W-1:0]   r_z;
    logic [SIDE_W-1:0]            r_side;

    assign xs         = i_x >>> SHIFT;
    assign ys         = i_y >>> SHIFT;
    assign step_angle = dtyp_pkg::atan_turn(ATAN_IDX);

    always_comb begin
        if (!i_y[W-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + step_angle;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - step_angle;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_z) && $stable(r_side))
        else $error("CORDIC stage dropped or altered a stalled transaction");

    a_stall_keeps_xy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> $stable(r_x) && $stable(r_y))
        else $error("CORDIC stage altered the vector of a stalled transaction");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_valid)
        else $error("CORDIC stage lost an accepted transaction");

endmodule

// ===== rtl/core/dtyp_cordic_pass.sv =====
// A full CORDIC vectoring pass built as a chain of registered iteration stages.
module dtyp_cordic_pass #(
    parameter int W      = 46,
    parameter int STEPS  = 16,
    parameter int SIDE_W = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [W-1:0]            i_x,
    input  logic signed [W-1:0]            i_y,
    input  logic [dtyp_pkg::ACC_W-1:0]     i_z,
    input  logic [SIDE_W-1:0]              i_side,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [W-1:0]            o_x,
    output logic [dtyp_pkg::ACC_W-1:0]     o_z,
    output logic [SIDE_W-1:0]              o_side
);

    logic                         c_valid [0:STEPS];
    logic                         c_ready [0:STEPS];
    logic signed [W-1:0]          c_x     [0:STEPS];
    logic signed [W-1:0]          c_y     [0:STEPS];
    logic [dtyp_pkg::ACC_W-1:0]   c_z     [0:STEPS];
    logic [SIDE_W-1:0]            c_side  [0:STEPS];

    assign c_valid[0]     = i_valid;
    assign c_x[0]         = i_x;
    assign c_y[0]         = i_y;
    assign c_z[0]         = i_z;
    assign c_side[0]      = i_side;
    assign o_ready        = c_ready[0];
    assign c_ready[STEPS] = i_ready;

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        dtyp_cordic_stage #(
            .W      (W),
            .SHIFT  (k),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_x     (c_x[k]),
            .i_y     (c_y[k]),
            .i_z     (c_z[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_x     (c_x[k+1]),
            .o_y     (c_y[k+1]),
            .o_z     (c_z[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    assign o_valid = c_valid[STEPS];
    assign o_x     = c_x[STEPS];
    assign o_z     = c_z[STEPS];
    assign o_side  = c_side[STEPS];

endmodule

// ===== rtl/core/direction_to_yaw_pitch.sv =====
// Top level: yaw and pitch of a direction vector through two chained CORDIC vectoring pipelines.
//
// The block accepts one direction transaction in every clock cycle unless the output stalls
// it, and returns one yaw and pitch transaction for each, in order. Its stages (CORDIC_STEPS
// capped at 24) are an input stage that pre-rotates the left half plane and scales dy by the
// CORDIC gain with one multiplier, one register stage per CORDIC iteration in the yaw pass,
// a stage that rounds yaw and forms the pitch vector, the iterations of the pitch pass, and
// the output register. Each stage holds its transaction while the next one is full, and an
// empty stage takes new data even when the output is stalled. Angles are binary, with
// 2^ANGLE_WIDTH units per turn; a zero vector gives yaw zero and pitch three quarters of a turn.
module direction_to_yaw_pitch #(
    parameter int COORD_WIDTH  = dtyp_pkg::DEF_COORD_WIDTH,
    parameter int ANGLE_WIDTH  = dtyp_pkg::DEF_ANGLE_WIDTH,
    parameter int CORDIC_STEPS = dtyp_pkg::DEF_CORDIC_STEPS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    dtyp_in_if.sink    i_in,
    dtyp_out_if.source o_out
);

    localparam int W      = COORD_WIDTH + dtyp_pkg::GUARD + dtyp_pkg::MARGIN;
    localparam int PROD_W = COORD_WIDTH + dtyp_pkg::KGAIN_W;
    localparam int DYK_W  = PROD_W - (dtyp_pkg::KGAIN_FRAC - dtyp_pkg::GUARD);
    localparam int STEPS  = (CORDIC_STEPS > dtyp_pkg::ATAN_LEN) ? dtyp_pkg::ATAN_LEN
                                                                : CORDIC_STEPS;
    localparam int SIDE1_W = PROD_W + 3;
    localparam int SIDE2_W = ANGLE_WIDTH + 1;
    localparam int ACC_W   = dtyp_pkg::ACC_W;
    localparam logic [ACC_W-1:0] ROUND_HALF = 32'd1 << (ACC_W - 1 - ANGLE_WIDTH);

    // Input stage.
    logic                      p0_ready;
    logic                      p1_in_ready;
    logic signed [W-1:0]       dz_ext;
    logic signed [W-1:0]       dx_ext;
    logic [COORD_WIDTH-1:0]    dy_abs;
    logic                      dz_neg;
    logic signed [W-1:0]       n0_x;
    logic signed [W-1:0]       n0_y;
    logic [ACC_W-1:0]          n0_z;
    logic [PROD_W-1:0]         n0_prod;
    logic                      n0_zero1;
    logic                      n0_zero2;
    logic                      r0_valid;
    logic signed [W-1:0]       r0_x;
    logic signed [W-1:0]       r0_y;
    logic [ACC_W-1:0]          r0_z;
    logic [SIDE1_W-1:0]        r0_side;

    assign dz_ext = {{(W - COORD_WIDTH - dtyp_pkg::GUARD){i_in.dz[COORD_WIDTH-1]}},
                     i_in.dz, {dtyp_pkg::GUARD{1'b0}}};
    assign dx_ext = {{(W - COORD_WIDTH - dtyp_pkg::GUARD){i_in.dx[COORD_WIDTH-1]}},
                     i_in.dx, {dtyp_pkg::GUARD{1'b0}}};
    assign dy_abs = i_in.dy[COORD_WIDTH-1] ? (~i_in.dy + 1'b1) : i_in.dy;
    assign dz_neg = i_in.dz[COORD_WIDTH-1];

    always_comb begin
        n0_x     = dz_neg ? -dz_ext : dz_ext;
        n0_y     = dz_neg ? -dx_ext : dx_ext;
        n0_z     = dz_neg ? dtyp_pkg::HALF_TURN : '0;
        n0_prod  = {{dtyp_pkg::KGAIN_W{1'b0}}, dy_abs}
                 * {{COORD_WIDTH{1'b0}}, dtyp_pkg::KGAIN_Q30};
        n0_zero1 = (i_in.dx == '0) && (i_in.dz == '0);
        n0_zero2 = n0_zero1 && (i_in.dy == '0);
    end

    assign p0_ready   = !r0_valid || p1_in_ready;
    assign i_in.ready = p0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (p0_ready) begin
            r0_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p0_ready && i_in.valid) begin
            r0_x    <= n0_x;
            r0_y    <= n0_y;
            r0_z    <= n0_z;
            r0_side <= {n0_zero2, n0_zero1, i_in.dy[COORD_WIDTH-1], n0_prod};
        end
    end

    // Yaw pass.
    logic                      p1_valid;
    logic                      p1_ready;
    logic signed [W-1:0]       p1_x;
    logic [ACC_W-1:0]          p1_z;
    logic [SIDE1_W-1:0]        p1_side;

    dtyp_cordic_pass #(
        .W      (W),
        .STEPS  (STEPS),
        .SIDE_W (SIDE1_W)
    ) u_pass_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_valid),
        .o_ready (p1_in_ready),
        .i_x     (r0_x),
        .i_y     (r0_y),
        .i_z     (r0_z),
        .i_side  (r0_side),
        .o_valid (p1_valid),
        .i_ready (p1_ready),
        .o_x     (p1_x),
        .o_z     (p1_z),
        .o_side  (p1_side)
    );

    // Middle stage: round yaw and build the pitch vector.
    logic [PROD_W-1:0]         s1_prod;
    logic                      s1_sign;
    logic                      s1_zero1;
    logic                      s1_zero2;
    logic [ACC_W-1:0]          yaw_acc;
    logic [ANGLE_WIDTH-1:0]    n1_yaw;
    logic signed [W-1:0]       n1_x;
    logic signed [W-1:0]       n1_y;
    logic [ACC_W-1:0]          n1_z;
    logic                      p2_in_ready;
    logic                      r1_valid;
    logic signed [W-1:0]       r1_x;
    logic signed [W-1:0]       r1_y;
    logic [ACC_W-1:0]          r1_z;
    logic [SIDE2_W-1:0]        r1_side;

    assign s1_prod  = p1_side[PROD_W-1:0];
    assign s1_sign  = p1_side[PROD_W];
    assign s1_zero1 = p1_side[PROD_W+1];
    assign s1_zero2 = p1_side[PROD_W+2];

    always_comb begin
        yaw_acc = (s1_zero1 ? '0 : p1_z) + ROUND_HALF;
        n1_yaw  = yaw_acc[ACC_W-1 -: ANGLE_WIDTH];
        n1_x    = {{(W - DYK_W){1'b0}}, s1_prod[PROD_W-1 -: DYK_W]};
        n1_y    = s1_sign ? -p1_x : p1_x;
        n1_z    = s1_sign ? dtyp_pkg::HALF_TURN : '0;
    end

    assign p1_ready = !r1_valid || p2_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (p1_ready) begin
            r1_valid <= p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_ready && p1_valid) begin
            r1_x    <= n1_x;
            r1_y    <= n1_y;
            r1_z    <= n1_z;
            r1_side <= {s1_zero2, n1_yaw};
        end
    end

    // Pitch pass.
    logic                      p2_valid;
    logic                      p2_ready;
    logic signed [W-1:0]       p2_x;
    logic [ACC_W-1:0]          p2_z;
    logic [SIDE2_W-1:0]        p2_side;

    dtyp_cordic_pass #(
        .W      (W),
        .STEPS  (STEPS),
        .SIDE_W (SIDE2_W)
    ) u_pass_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_valid),
        .o_ready (p2_in_ready),
        .i_x     (r1_x),
        .i_y     (r1_y),
        .i_z     (r1_z),
        .i_side  (r1_side),
        .o_valid (p2_valid),
        .i_ready (p2_ready),
        .o_x     (p2_x),
        .o_z     (p2_z),
        .o_side  (p2_side)
    );

    // Output register.
    logic [ACC_W-1:0]          pitch_acc;
    logic [ANGLE_WIDTH-1:0]    n_pitch;
    logic                      r_out_valid;
    logic [ANGLE_WIDTH-1:0]    r_out_yaw;
    logic [ANGLE_WIDTH-1:0]    r_out_pitch;

    always_comb begin
        pitch_acc = (p2_side[ANGLE_WIDTH] ? '0 : p2_z) - dtyp_pkg::QUARTER_TURN + ROUND_HALF;
        n_pitch   = pitch_acc[ACC_W-1 -: ANGLE_WIDTH];
    end

    assign p2_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (p2_ready) begin
            r_out_valid <= p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p2_ready && p2_valid) begin
            r_out_yaw   <= p2_side[ANGLE_WIDTH-1:0];
            r_out_pitch <= n_pitch;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.yaw   = r_out_yaw;
    assign o_out.pitch = r_out_pitch;

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r0_valid |-> i_in.ready)
        else $error("Input stage is empty but refuses a transaction");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("Result presented straight after reset");

    a_mid_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid && !p2_in_ready |=> r1_valid && $stable(r1_side))
        else $error("Middle stage lost a stalled transaction");

    a_pitch_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p2_valid |-> !p2_x[W-1])
        else $error("Pitch pass produced a negative length");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for direction_to_yaw_pitch against a bit-exact angle model.
module tb;

    localparam int CW          = dtyp_pkg::DEF_COORD_WIDTH;
    localparam int AW          = dtyp_pkg::DEF_ANGLE_WIDTH;
    localparam int STEPS       = dtyp_pkg::DEF_CORDIC_STEPS;
    localparam int LUT_LEN     = 24;
    localparam int GUARD_BITS  = 26;
    localparam int LATENCY     = 2 * STEPS + 3;
    localparam int HOLD_CYCLES = 300;

    localparam longint      SCALE      = 64'sd1 << GUARD_BITS;
    localparam logic [63:0] GAIN_Q30   = 64'd1768195363;
    localparam logic [31:0] TURN_HALF  = 32'h8000_0000;
    localparam logic [31:0] TURN_QUART = 32'h4000_0000;

    localparam logic [31:0] ATAN_LUT [0:LUT_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic [CW-1:0] dx;
        logic [CW-1:0] dy;
        logic [CW-1:0] dz;
    } dir_t;

    typedef struct packed {
        logic [AW-1:0] yaw;
        logic [AW-1:0] pitch;
    } angles_t;

    logic clk;
    logic rst_n;

    dtyp_in_if  #(.COORD_WIDTH(CW)) dir_if ();
    dtyp_out_if #(.ANGLE_WIDTH(AW)) ang_if ();

    direction_to_yaw_pitch #(
        .COORD_WIDTH  (CW),
        .ANGLE_WIDTH  (AW),
        .CORDIC_STEPS (STEPS)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (dir_if),
        .o_out   (ang_if)
    );

    dir_t    pending_dirs[$];
    angles_t expected_angles[$];
    dir_t    next_dir;
    angles_t seen_angles;
    angles_t want_angles;
    int      send_idle_pct;
    int      stall_pct;
    int      error_count;
    logic    hold_armed;
    int      hold_count;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] cordic_vector(input longint x0, input longint y0,
                                                  output longint len);
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] z;
        int          steps;
        x = x0;
        y = y0;
        z = '0;
        steps = (STEPS > LUT_LEN) ? LUT_LEN : STEPS;
        if (x == 0 && y == 0) begin
            len = 0;
            return '0;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = TURN_HALF;
        end
        for (int i = 0; i < steps; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_LUT[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_LUT[i];
            end
        end
        len = x;
        return z;
    endfunction

    function automatic logic [AW-1:0] round_angle(input logic [31:0] z);
        logic [32:0] r;
        r = {1'b0, z} + (33'd1 << (31 - AW));
        return r[31 -: AW];
    endfunction

    function automatic angles_t predict_angles(input dir_t d);
        longint      horiz;
        longint      spare;
        longint      dy_gained;
        longint      dy_signed;
        logic [63:0] dy_abs;
        logic [31:0] yaw_acc;
        logic [31:0] pitch_acc;
        angles_t     a;
        yaw_acc = cordic_vector(longint'($signed(d.dz)) * SCALE,
                                longint'($signed(d.dx)) * SCALE, horiz);
        dy_signed = longint'($signed(d.dy));
        dy_abs = (dy_signed < 0) ? 64'(-dy_signed) : 64'(dy_signed);
        dy_abs = (dy_abs * GAIN_Q30) >> (30 - GUARD_BITS);
        dy_gained = $signed(dy_abs);
        if (dy_signed < 0) begin
            dy_gained = -dy_gained;
        end
        pitch_acc = cordic_vector(dy_gained, horiz, spare) - TURN_QUART;
        a.yaw = round_angle(yaw_acc);
        a.pitch = round_angle(pitch_acc);
        return a;
    endfunction

    function automatic logic [CW-1:0] random_coord();
        case ($urandom_range(0, 7)) inside
            [0:3]:      return CW'($urandom);
            4:          return CW'($urandom_range(0, 32)) - CW'(16);
            5:          return '0;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return {1'b1, {(CW-1){1'b0}}};
                    1:       return {1'b0, {(CW-1){1'b1}}};
                    2:       return CW'(1);
                    3:       return '1;
                    default: return {1'b1, {(CW-2){1'b0}}, 1'b1};
                endcase
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic push_dir(input int x, input int y, input int z);
        pending_dirs.push_back('{dx: CW'(x), dy: CW'(y), dz: CW'(z)});
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            pending_dirs.push_back('{dx: random_coord(), dy: random_coord(), dz: random_coord()});
        end
        while (pending_dirs.size() != 0 || dir_if.valid) @(negedge clk);
    endtask

    // Driver: a new transaction is offered only once the previous one has been taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            dir_if.valid <= 1'b0;
        end else if (!dir_if.valid || dir_if.ready) begin
            if (pending_dirs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_dir = pending_dirs.pop_front();
                dir_if.valid <= 1'b1;
                dir_if.dx <= next_dir.dx;
                dir_if.dy <= next_dir.dy;
                dir_if.dz <= next_dir.dz;
            end else begin
                dir_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: one long hold-off once armed, random back-pressure otherwise.
    always @(posedge clk) begin
        if (!rst_n) begin
            ang_if.ready <= 1'b0;
            hold_count <= 0;
        end else if (hold_armed && hold_count < HOLD_CYCLES) begin
            ang_if.ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            ang_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor: predicts on each accepted input and checks each accepted output in order.
    always @(posedge clk) begin
        if (rst_n) begin
            if (dir_if.valid && dir_if.ready) begin
                expected_angles.push_back(predict_angles('{dx: dir_if.dx, dy: dir_if.dy,
                                                           dz: dir_if.dz}));
            end
            if (ang_if.valid && ang_if.ready) begin
                seen_angles = '{yaw: ang_if.yaw, pitch: ang_if.pitch};
                if (expected_angles.size() == 0) begin
                    report_mismatch($sformatf("unexpected result yaw %0d pitch %0d",
                                              seen_angles.yaw, seen_angles.pitch));
                end else begin
                    want_angles = expected_angles.pop_front();
                    if (seen_angles.yaw !== want_angles.yaw) begin
                        report_mismatch($sformatf("yaw %0d, expected %0d",
                                                  seen_angles.yaw, want_angles.yaw));
                    end
                    if (seen_angles.pitch !== want_angles.pitch) begin
                        report_mismatch($sformatf("pitch %0d, expected %0d",
                                                  seen_angles.pitch, want_angles.pitch));
                    end
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("direction_to_yaw_pitch: mismatch");
        $finish;
    end

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        dir_if.valid = 1'b0;
        dir_if.dx = '0;
        dir_if.dy = '0;
        dir_if.dz = '0;
        ang_if.ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        error_count = 0;
        hold_armed = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero vector, axis extremes, the left half plane and purely vertical vectors.
        push_dir(0, 0, 0);
        push_dir(32767, 0, 0);
        push_dir(-32768, 0, 0);
        push_dir(0, 32767, 0);
        push_dir(0, -32768, 0);
        push_dir(0, 1, 0);
        push_dir(0, -1, 0);
        push_dir(0, 0, 32767);
        push_dir(0, 0, -32768);
        push_dir(1, 0, 0);
        push_dir(-1, 0, 0);
        push_dir(0, 0, 1);
        push_dir(0, 0, -1);
        push_dir(32767, 32767, 32767);
        push_dir(-32768, -32768, -32768);
        push_dir(32767, -32768, -32768);
        push_dir(-32768, 32767, 32767);
        push_dir(100, 0, -100);
        push_dir(-100, 5, -100);
        push_dir(0, -7, -3);
        push_dir(-32768, 0, -32768);
        push_dir(1, -1, -1);
        while (pending_dirs.size() != 0 || dir_if.valid) @(negedge clk);

        run_random(150, 0, 0);
        run_random(130, 58, 0);
        run_random(130, 0, 58);
        run_random(130, 11, 11);

        // Receiver holds off for a long stretch while the sender keeps offering.
        hold_armed = 1'b1;
        run_random(110, 0, 0);

        while (expected_angles.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (error_count == 0) begin
            $display("direction_to_yaw_pitch: match");
        end else begin
            $display("direction_to_yaw_pitch: mismatch");
        end
        $finish;
    end

endmodule
